>>> src/uitp_pkg.sv
// uitp_pkg: constants, TLV type codes, field codes and the capability GUID table
// used by the user info TLV parser. No dependencies.
package uitp_pkg;

  localparam int MAX_NAME_LEN      = 16;
  localparam int CAP_TABLE_ENTRIES = 10;
  localparam int CAP_ROWS          = 10;
  localparam int CAP_USED          = (CAP_TABLE_ENTRIES < CAP_ROWS) ? CAP_TABLE_ENTRIES : CAP_ROWS;
  localparam int GUID_BYTES        = 16;

  localparam logic [7:0] NAME_LIMIT = 8'(MAX_NAME_LEN - 1);

  localparam logic [CAP_ROWS-1:0] CAP_ALL  = {CAP_ROWS{1'b1}};
  localparam logic [CAP_ROWS-1:0] CAP_MASK = CAP_ROWS'((64'd1 << CAP_USED) - 64'd1);

  localparam int TDATA_W = 232;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic [15:0] TLV_PAD       = 16'h0000;
  localparam logic [15:0] TLV_FLAGS     = 16'h0001;
  localparam logic [15:0] TLV_MEMBER    = 16'h0002;
  localparam logic [15:0] TLV_ONLINE    = 16'h0003;
  localparam logic [15:0] TLV_IDLE      = 16'h0004;
  localparam logic [15:0] TLV_STATUS    = 16'h0006;
  localparam logic [15:0] TLV_PEER      = 16'h000a;
  localparam logic [15:0] TLV_CAPS      = 16'h000d;
  localparam logic [15:0] TLV_SESSION_A = 16'h000f;
  localparam logic [15:0] TLV_SESSION_B = 16'h0010;

  typedef logic [2:0] fld_t;
  localparam fld_t FLD_NONE    = 3'd0;
  localparam fld_t FLD_FLAGS   = 3'd1;
  localparam fld_t FLD_MEMBER  = 3'd2;
  localparam fld_t FLD_ONLINE  = 3'd3;
  localparam fld_t FLD_IDLE    = 3'd4;
  localparam fld_t FLD_STATUS  = 3'd5;
  localparam fld_t FLD_PEER    = 3'd6;
  localparam fld_t FLD_SESSION = 3'd7;

  localparam logic [7:0] CAP_TABLE [CAP_ROWS][GUID_BYTES] = '{
    '{8'h09,8'h46,8'h13,8'h46,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h41,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h45,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h74,8'h8f,8'h24,8'h20,8'h62,8'h87,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h48,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h43,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h47,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h4a,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h4a,8'h4c,8'h7f,8'h11,8'hd1,8'h22,8'h82,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00},
    '{8'h09,8'h46,8'h13,8'h4b,8'h4c,8'h7f,8'h11,8'hd1,8'h82,8'h22,8'h44,8'h45,8'h53,8'h54,8'h00,8'h00}
  };

  // entries whose byte at pos equals b
  function automatic logic [CAP_ROWS-1:0] cap_byte_hits(input logic [3:0] pos,
                                                        input logic [7:0] b);
    logic [CAP_ROWS-1:0] hits;
    hits = '0;
    for (int e = 0; e < CAP_ROWS; e++) begin
      hits[e] = (CAP_TABLE[e][pos] == b);
    end
    return hits & CAP_MASK;
  endfunction

  // entries whose bytes from pos p to the end are all zero
  function automatic logic [CAP_ROWS-1:0] cap_pad_mask(input logic [3:0] p);
    logic [CAP_ROWS-1:0] ok;
    ok = '0;
    for (int e = 0; e < CAP_ROWS; e++) begin
      ok[e] = 1'b1;
      for (int q = 0; q < GUID_BYTES; q++) begin
        if (q >= int'(p) && CAP_TABLE[e][q] != 8'h00) begin
          ok[e] = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  function automatic fld_t field_of(input logic [15:0] tlv_type, input logic flags_seen);
    fld_t f;
    case (tlv_type)
      TLV_FLAGS:     f = flags_seen ? FLD_NONE : FLD_FLAGS;
      TLV_MEMBER:    f = FLD_MEMBER;
      TLV_ONLINE:    f = FLD_ONLINE;
      TLV_IDLE:      f = FLD_IDLE;
      TLV_STATUS:    f = FLD_STATUS;
      TLV_PEER:      f = FLD_PEER;
      TLV_SESSION_A: f = FLD_SESSION;
      TLV_SESSION_B: f = FLD_SESSION;
      default:       f = FLD_NONE;
    endcase
    return f;
  endfunction

endpackage

>>> src/user_info_tlv_parser.sv
// user_info_tlv_parser: byte-serial parser for user info records (name, warning
// level, TLV list with capability GUID matching). Depends on uitp_pkg.
//
// Takes one record byte per cycle, with no gaps needed between bytes or records.
// Each byte passes an input register, then parse logic that updates the record
// state and loads the result register. The capability GUID compare checks all
// table entries in parallel against the current byte, so type 13 data also runs
// at one byte per cycle. Name bytes, up to the first 15, come out as kind 0 words,
// the completed record as one kind 1 word after the last TLV; backpressure on the
// output stalls the input.
module user_info_tlv_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte
  input  logic                         s_tuser,   // record_start
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // name_byte, warning_level, user_flags, member_since, online_since,
  // idle_seconds, status_word, peer_ip, capability_bits, session_seconds,
  // bytes_consumed, zero fill
  output logic [uitp_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser    // item_kind
);
  import uitp_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_NAME  = 3'd1;
  localparam logic [2:0] PH_WARN  = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_HEAD  = 3'd4;
  localparam logic [2:0] PH_VALUE = 3'd5;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       en;

  // parse state
  logic [2:0]          phase, phase_next;
  logic [7:0]          name_left, name_left_next;
  logic [7:0]          name_idx, name_idx_next;
  logic [7:0]          name_limit, name_limit_next;
  logic [15:0]         tlvs_left, tlvs_left_next;
  logic [15:0]         cur_type, cur_type_next;
  logic [15:0]         val_left, val_left_next;
  logic [15:0]         offset, offset_next;
  fld_t                fld, fld_next;
  logic [CAP_ROWS-1:0] match_vec, match_vec_next;
  logic                flags_seen, flags_seen_next;
  logic [15:0]         byte_count, byte_count_next;

  // record fields
  logic [15:0]         warning, warning_next;
  logic [15:0]         flags, flags_next;
  logic [31:0]         member, member_next;
  logic [31:0]         online, online_next;
  logic [15:0]         idle, idle_next;
  logic [15:0]         status, status_next;
  logic [31:0]         peer, peer_next;
  logic [CAP_ROWS-1:0] caps, caps_next;
  logic [31:0]         session, session_next;

  logic emit_name, emit_rec;

  // capability compare
  logic [3:0]          gpos;
  logic [CAP_ROWS-1:0] vec_after, commit_vec, first_hit;
  logic                last_val;

  assign en       = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || en;

  assign gpos       = offset[3:0];
  assign vec_after  = match_vec & cap_byte_hits(gpos, in_byte);
  assign commit_vec = (gpos == 4'hf) ? vec_after : (vec_after & cap_pad_mask(gpos + 4'd1));
  assign first_hit  = commit_vec & (~commit_vec + CAP_ROWS'(1)) & CAP_MASK;
  assign last_val   = (val_left == 16'd1);

  always_comb begin
    phase_next      = phase;
    name_left_next  = name_left;
    name_idx_next   = name_idx;
    name_limit_next = name_limit;
    tlvs_left_next  = tlvs_left;
    cur_type_next   = cur_type;
    val_left_next   = val_left;
    offset_next     = offset;
    fld_next        = fld;
    match_vec_next  = match_vec;
    flags_seen_next = flags_seen;
    byte_count_next = byte_count;
    warning_next    = warning;
    flags_next      = flags;
    member_next     = member;
    online_next     = online;
    idle_next       = idle;
    status_next     = status;
    peer_next       = peer;
    caps_next       = caps;
    session_next    = session;
    emit_name       = 1'b0;
    emit_rec        = 1'b0;

    if (in_start) begin
      phase_next      = (in_byte == 8'd0) ? PH_WARN : PH_NAME;
      name_left_next  = in_byte;
      name_idx_next   = '0;
      name_limit_next = (in_byte < NAME_LIMIT) ? in_byte : NAME_LIMIT;
      tlvs_left_next  = '0;
      cur_type_next   = '0;
      val_left_next   = '0;
      offset_next     = '0;
      fld_next        = FLD_NONE;
      match_vec_next  = CAP_ALL;
      flags_seen_next = 1'b0;
      byte_count_next = 16'd1;
      warning_next    = '0;
      flags_next      = '0;
      member_next     = '0;
      online_next     = '0;
      idle_next       = '0;
      status_next     = '0;
      peer_next       = '0;
      caps_next       = '0;
      session_next    = '0;
    end else if (phase != PH_IDLE) begin
      if (byte_count != 16'hffff) begin
        byte_count_next = byte_count + 16'd1;
      end
      case (phase)
        PH_NAME: begin
          name_idx_next  = name_idx + 8'd1;
          name_left_next = name_left - 8'd1;
          if (name_left == 8'd1) begin
            phase_next = PH_WARN;
          end
          emit_name = (name_idx < name_limit);
        end
        PH_WARN: begin
          warning_next = {warning[7:0], in_byte};
          offset_next  = offset + 16'd1;
          if (offset == 16'd1) begin
            offset_next = '0;
            phase_next  = PH_COUNT;
          end
        end
        PH_COUNT: begin
          tlvs_left_next = {tlvs_left[7:0], in_byte};
          offset_next    = offset + 16'd1;
          if (offset == 16'd1) begin
            offset_next = '0;
            if ({tlvs_left[7:0], in_byte} == 16'd0) begin
              emit_rec = 1'b1;
            end else begin
              phase_next = PH_HEAD;
            end
          end
        end
        PH_HEAD: begin
          case (offset[1:0])
            2'd0: begin
              cur_type_next = {cur_type[7:0], in_byte};
              offset_next   = 16'd1;
            end
            2'd1: begin
              cur_type_next = {cur_type[7:0], in_byte};
              offset_next   = ({cur_type[7:0], in_byte} == TLV_PAD) ? 16'd0 : 16'd2;
            end
            2'd2: begin
              val_left_next = {val_left[7:0], in_byte};
              offset_next   = 16'd3;
            end
            default: begin
              val_left_next = {val_left[7:0], in_byte};
              offset_next   = '0;
              fld_next      = field_of(cur_type, flags_seen);
              case (field_of(cur_type, flags_seen))
                FLD_FLAGS:   flags_next   = '0;
                FLD_MEMBER:  member_next  = '0;
                FLD_ONLINE:  online_next  = '0;
                FLD_IDLE:    idle_next    = '0;
                FLD_STATUS:  status_next  = '0;
                FLD_PEER:    peer_next    = '0;
                FLD_SESSION: session_next = '0;
                default: ;
              endcase
              if (cur_type == TLV_FLAGS) begin
                flags_seen_next = 1'b1;
              end
              if (cur_type == TLV_CAPS && {val_left[7:0], in_byte} != 16'd0) begin
                caps_next      = '0;
                match_vec_next = CAP_ALL;
              end
              if ({val_left[7:0], in_byte} == 16'd0) begin
                tlvs_left_next = tlvs_left - 16'd1;
                if (tlvs_left == 16'd1) begin
                  emit_rec = 1'b1;
                end
              end else begin
                phase_next = PH_VALUE;
              end
            end
          endcase
        end
        PH_VALUE: begin
          case (fld)
            FLD_FLAGS: begin
              if (offset == 16'd0) flags_next[15:8] = in_byte;
              if (offset == 16'd1) flags_next[7:0]  = in_byte;
            end
            FLD_IDLE: begin
              if (offset == 16'd0) idle_next[15:8] = in_byte;
              if (offset == 16'd1) idle_next[7:0]  = in_byte;
            end
            FLD_STATUS: begin
              if (offset == 16'd2) status_next[15:8] = in_byte;
              if (offset == 16'd3) status_next[7:0]  = in_byte;
            end
            FLD_MEMBER: begin
              if (offset == 16'd0) member_next[31:24] = in_byte;
              if (offset == 16'd1) member_next[23:16] = in_byte;
              if (offset == 16'd2) member_next[15:8]  = in_byte;
              if (offset == 16'd3) member_next[7:0]   = in_byte;
            end
            FLD_ONLINE: begin
              if (offset == 16'd0) online_next[31:24] = in_byte;
              if (offset == 16'd1) online_next[23:16] = in_byte;
              if (offset == 16'd2) online_next[15:8]  = in_byte;
              if (offset == 16'd3) online_next[7:0]   = in_byte;
            end
            FLD_PEER: begin
              if (offset == 16'd0) peer_next[31:24] = in_byte;
              if (offset == 16'd1) peer_next[23:16] = in_byte;
              if (offset == 16'd2) peer_next[15:8]  = in_byte;
              if (offset == 16'd3) peer_next[7:0]   = in_byte;
            end
            FLD_SESSION: begin
              if (offset == 16'd0) session_next[31:24] = in_byte;
              if (offset == 16'd1) session_next[23:16] = in_byte;
              if (offset == 16'd2) session_next[15:8]  = in_byte;
              if (offset == 16'd3) session_next[7:0]   = in_byte;
            end
            default: ;
          endcase
          if (cur_type == TLV_CAPS) begin
            match_vec_next = vec_after;
            // full block, or a partial last block padded with zeros
            if (gpos == 4'hf || last_val) begin
              caps_next      = caps | first_hit;
              match_vec_next = CAP_ALL;
            end
          end
          offset_next   = offset + 16'd1;
          val_left_next = val_left - 16'd1;
          if (last_val) begin
            offset_next    = '0;
            tlvs_left_next = tlvs_left - 16'd1;
            if (tlvs_left == 16'd1) begin
              emit_rec = 1'b1;
            end else begin
              phase_next = PH_HEAD;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
      if (emit_rec) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      match_vec  <= CAP_ALL;
      flags_seen <= 1'b0;
      byte_count <= '0;
      name_left  <= '0;
      name_idx   <= '0;
      name_limit <= '0;
      tlvs_left  <= '0;
      cur_type   <= '0;
      val_left   <= '0;
      offset     <= '0;
      fld        <= FLD_NONE;
    end else if (en) begin
      phase      <= phase_next;
      match_vec  <= match_vec_next;
      flags_seen <= flags_seen_next;
      byte_count <= byte_count_next;
      name_left  <= name_left_next;
      name_idx   <= name_idx_next;
      name_limit <= name_limit_next;
      tlvs_left  <= tlvs_left_next;
      cur_type   <= cur_type_next;
      val_left   <= val_left_next;
      offset     <= offset_next;
      fld        <= fld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      warning <= warning_next;
      flags   <= flags_next;
      member  <= member_next;
      online  <= online_next;
      idle    <= idle_next;
      status  <= status_next;
      peer    <= peer_next;
      caps    <= caps_next;
      session <= session_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= emit_name || emit_rec;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (en) begin
      if (emit_rec) begin
        m_tuser <= KIND_RECORD;
        m_tdata <= {6'd0, byte_count_next, session_next, caps_next, peer_next,
                    status_next, idle_next, online_next, member_next, flags_next,
                    warning_next, 8'd0};
      end else begin
        m_tuser <= KIND_NAME;
        m_tdata <= {{(TDATA_W-8){1'b0}}, in_byte};
      end
    end
  end

`ifndef SYNTHESIS
  a_guid_idle_between_tlvs: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEAD) |-> (match_vec == CAP_ALL))
    else $error("guid match vector not reset at tlv boundary");

  a_idle_after_record: assert property (@(posedge clk) disable iff (rst)
    (en && emit_rec) |=> (phase == PH_IDLE))
    else $error("parser not idle after record word");

  a_name_word_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_NAME) |-> (m_tdata[TDATA_W-1:8] == '0))
    else $error("name word carries record fields");

  a_record_counts_bytes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_RECORD) |-> (m_tdata[225:210] != 16'd0))
    else $error("record word with zero byte count");

  a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && !$past(en)))
    else $error("result register overwritten while stalled");
`endif

endmodule
